[src/hrc_pkg.sv]
// hrc_pkg: shared types and codes for the histogram range colorizer.
// No dependencies; used by every file in src.
package hrc_pkg;

   localparam int CNT_W    = 11;   // iteration count field width
   localparam int PIX_W    = 18;   // pixel index field width
   localparam int SUM_W    = 19;   // histogram entry and total width
   localparam int CHAN_W   = 8;    // one color channel
   localparam int COLOR_W  = 24;
   localparam int START_W  = 16;   // one range start bound
   localparam int SLOTS    = 4;    // range start/total slots
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 64;

   localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};

   // commands
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_LOAD   = 2'd1;
   localparam logic [1:0] CMD_TOTALS = 2'd2;
   localparam logic [1:0] CMD_DRAW   = 2'd3;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_RANGE_COUNT  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_RANGE_STARTS = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_RANGE_TOP    = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_COLOR_ZERO   = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_COLOR_ONE    = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_COLOR_TWO    = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_COLOR_THREE  = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_COLOR_FOUR   = 3'd7;

   typedef struct packed {
      logic [1:0]       command;
      logic [PIX_W-1:0] pixel_index;
      logic [CNT_W-1:0] iteration_count;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel_position;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rsp_word_type;

   // one channel blend job
   typedef struct packed {
      logic [CHAN_W-1:0] s;
      logic [CHAN_W-1:0] e;
      logic [SUM_W-1:0]  sum;
      logic [SUM_W-1:0]  total;
   } blend_req_type;

endpackage

[src/hrc_blend.sv]
// hrc_blend: one color channel, floor((s*(T-sum) + e*sum) / T), sum clamped to T.
// Depends on hrc_pkg. A multiply state, then eight restoring divide steps.
module hrc_blend (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  hrc_pkg::blend_req_type      job,
   output logic                        done,
   output logic [hrc_pkg::CHAN_W-1:0]  value
);

   localparam int NUM_W = hrc_pkg::CHAN_W + hrc_pkg::SUM_W;

   localparam logic [1:0] BL_IDLE = 2'd0;
   localparam logic [1:0] BL_MUL  = 2'd1;
   localparam logic [1:0] BL_DIV  = 2'd2;

   logic [1:0]                  state_ff, state_in;
   hrc_pkg::blend_req_type      job_ff, job_in;
   logic [NUM_W-1:0]            rem_ff, rem_in;
   logic [2:0]                  bit_ff, bit_in;
   logic [hrc_pkg::CHAN_W-1:0]  q_ff, q_in;
   logic                        done_ff, done_in;

   logic [hrc_pkg::SUM_W-1:0]   sum_c;
   logic [NUM_W-1:0]            trial;

   always_comb begin
      sum_c = (job_ff.sum > job_ff.total) ? job_ff.total : job_ff.sum;
      trial = NUM_W'(job_ff.total) << bit_ff;
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      case (state_ff)
         BL_IDLE: begin
            if (start) begin
               job_in   = job;
               state_in = BL_MUL;
            end
         end
         BL_MUL: begin
            // zero total keeps the start color
            if (job_ff.total == '0) begin
               q_in     = job_ff.s;
               done_in  = 1'b1;
               state_in = BL_IDLE;
            end else begin
               rem_in   = NUM_W'(job_ff.s * (job_ff.total - sum_c))
                        + NUM_W'(job_ff.e * sum_c);
               bit_in   = 3'd7;
               q_in     = '0;
               state_in = BL_DIV;
            end
         end
         BL_DIV: begin
            if (rem_ff >= trial) begin
               rem_in       = rem_ff - trial;
               q_in[bit_ff] = 1'b1;
            end
            if (bit_ff == 3'd0) begin
               done_in  = 1'b1;
               state_in = BL_IDLE;
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end
         default: state_in = BL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      job_ff <= job_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      q_ff   <= q_in;
   end

   assign done  = done_ff;
   assign value = q_ff;

endmodule

[src/histogram_range_colorizer.sv]
// histogram_range_colorizer: histogram-equalized coloring of an escape-time frame.
// Depends on hrc_pkg and hrc_blend.
// A draw walks the histogram from the range start up to the count through the single
// histogram port, then runs the three channels in turn through one blend divider;
// a count at MAX_ITER or above gives black. One item at a time. Reset runs a
// clearing pass over the histogram with req_stall high; configuration writes are
// taken throughout.
module histogram_range_colorizer #(
   parameter int MAX_ITER     = 1024,
   parameter int FRAME_WIDTH  = 512,
   parameter int FRAME_HEIGHT = 512,
   parameter int MAX_RANGES   = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  hrc_pkg::req_word_type        req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output hrc_pkg::rsp_word_type        rsp_word,
   input  logic                         csr_write,
   input  logic [hrc_pkg::CSR_IW-1:0]   csr_index,
   input  logic [hrc_pkg::CSR_DW-1:0]   csr_data
);

   localparam int PIXELS  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int FRAME_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int HIST_AW  = $clog2(MAX_ITER);
   localparam int CMP_W    = 25;
   localparam int CNT_W    = hrc_pkg::CNT_W;
   localparam int SUM_W    = hrc_pkg::SUM_W;

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_CLEAR      = 4'd1;
   localparam logic [3:0] ST_LOAD_WR    = 4'd2;
   localparam logic [3:0] ST_TOT_RD     = 4'd3;
   localparam logic [3:0] ST_TOT_ACC    = 4'd4;
   localparam logic [3:0] ST_DRW_CNT    = 4'd5;
   localparam logic [3:0] ST_DRW_RD     = 4'd6;
   localparam logic [3:0] ST_DRW_ACC    = 4'd7;
   localparam logic [3:0] ST_BLEND_GO   = 4'd8;
   localparam logic [3:0] ST_BLEND_WAIT = 4'd9;
   localparam logic [3:0] ST_OUT        = 4'd10;

   // memories
   logic [CNT_W-1:0] frame_mem [PIXELS];
   logic [SUM_W-1:0] hist_mem  [MAX_ITER];

   logic                 frm_we;
   logic [FRAME_AW-1:0]  frm_addr;
   logic [CNT_W-1:0]     frm_wdata;
   logic [CNT_W-1:0]     frm_q_ff;
   logic                 hist_we;
   logic [HIST_AW-1:0]   hist_addr;
   logic [SUM_W-1:0]     hist_wdata;
   logic [SUM_W-1:0]     hist_q_ff;

   // configuration
   logic [2:0]                     range_count_ff;
   logic [hrc_pkg::CSR_DW-1:0]     range_starts_ff;
   logic [hrc_pkg::COLOR_W-1:0]    color_ff [5];

   // control and datapath
   logic [3:0]              state_ff, state_in;
   logic [HIST_AW-1:0]      sweep_ff, sweep_in;
   hrc_pkg::req_word_type   word_ff, word_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [1:0]              rng_ff, rng_in;
   logic [CNT_W-1:0]        walk_ff, walk_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [1:0]              chan_ff, chan_in;
   logic [hrc_pkg::COLOR_W-1:0] rgb_ff, rgb_in;
   logic [SUM_W-1:0]        totals_ff [hrc_pkg::SLOTS];
   logic [SUM_W-1:0]        totals_in [hrc_pkg::SLOTS];
   logic                    rsp_valid_ff, rsp_valid_in;
   hrc_pkg::rsp_word_type   rsp_word_ff, rsp_word_in;

   logic                    blend_start;
   hrc_pkg::blend_req_type  blend_job;
   logic                    blend_done;
   logic [hrc_pkg::CHAN_W-1:0] blend_value;

   logic [2:0]              n_used;
   logic [CNT_W-1:0]        req_cnt_sat;
   logic                    req_in_frame;
   logic [1:0]              rng_next;
   logic [SUM_W:0]          add_tot;
   logic [SUM_W:0]          add_sum;
   logic [hrc_pkg::START_W-1:0] draw_start;
   logic [1:0]              draw_rng;

   function automatic logic [hrc_pkg::START_W-1:0] start_of(
      input logic [hrc_pkg::CSR_DW-1:0] starts, input logic [1:0] idx);
      return starts[hrc_pkg::START_W*idx +: hrc_pkg::START_W];
   endfunction

   // last range whose start the count reaches
   function automatic logic [1:0] range_for(
      input logic [CNT_W-1:0] c, input logic [2:0] n,
      input logic [hrc_pkg::CSR_DW-1:0] starts);
      logic [1:0] r;
      logic       found;
      r     = 2'(n - 3'd1);
      found = 1'b0;
      for (int i = 1; i < hrc_pkg::SLOTS; i++) begin
         if (!found && 3'(i) < n &&
             starts[hrc_pkg::START_W*i +: hrc_pkg::START_W] > 16'(c)) begin
            r     = 2'(i - 1);
            found = 1'b1;
         end
      end
      return r;
   endfunction

   // memory ports
   always_ff @(posedge clock) begin
      if (frm_we) frame_mem[frm_addr] <= frm_wdata;
      frm_q_ff <= frame_mem[frm_addr];
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_addr] <= hist_wdata;
      hist_q_ff <= hist_mem[hist_addr];
   end

   // range count clamped to 1..MAX_RANGES
   always_comb begin
      if (range_count_ff == 3'd0) n_used = 3'd1;
      else if (32'(range_count_ff) > MAX_RANGES) n_used = 3'(MAX_RANGES);
      else n_used = range_count_ff;
   end

   always_comb begin
      req_in_frame = CMP_W'(req_word.pixel_index) < CMP_W'(PIXELS);
      req_cnt_sat  = (17'(req_word.iteration_count) > 17'(MAX_ITER))
                   ? CNT_W'(MAX_ITER) : req_word.iteration_count;
      rng_next = rng_ff;
      if (3'(rng_ff) + 3'd1 < n_used &&
          17'(sweep_ff) >= 17'(start_of(range_starts_ff, rng_ff + 2'd1)))
         rng_next = rng_ff + 2'd1;
      add_tot    = (SUM_W+1)'(totals_ff[rng_next]) + (SUM_W+1)'(hist_q_ff);
      add_sum    = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(hist_q_ff);
      draw_rng   = range_for(frm_q_ff, n_used, range_starts_ff);
      draw_start = start_of(range_starts_ff, draw_rng);
   end

   // main sequencer
   always_comb begin
      state_in    = state_ff;
      sweep_in    = sweep_ff;
      word_in     = word_ff;
      cnt_in      = cnt_ff;
      rng_in      = rng_ff;
      walk_in     = walk_ff;
      sum_in      = sum_ff;
      chan_in     = chan_ff;
      rgb_in      = rgb_ff;
      totals_in   = totals_ff;
      rsp_word_in = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      frm_we      = 1'b0;
      frm_addr    = FRAME_AW'(req_word.pixel_index);
      frm_wdata   = req_cnt_sat;
      hist_we     = 1'b0;
      hist_addr   = HIST_AW'(walk_ff);
      hist_wdata  = '0;
      blend_start = 1'b0;
      blend_job.s     = color_ff[rng_ff][8*(2-chan_ff) +: 8];
      blend_job.e     = color_ff[3'(rng_ff) + 3'd1][8*(2-chan_ff) +: 8];
      blend_job.sum   = sum_ff;
      blend_job.total = totals_ff[rng_ff];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               word_in = req_word;
               case (req_word.command)
                  hrc_pkg::CMD_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  hrc_pkg::CMD_LOAD: begin
                     if (req_in_frame) begin
                        frm_we = 1'b1;
                        // issue the histogram read for the increment
                        if (17'(req_cnt_sat) < 17'(MAX_ITER)) begin
                           hist_addr = HIST_AW'(req_cnt_sat);
                           state_in  = ST_LOAD_WR;
                        end
                     end
                  end
                  hrc_pkg::CMD_TOTALS: begin
                     sweep_in = '0;
                     rng_in   = '0;
                     state_in = ST_TOT_RD;
                  end
                  default: begin
                     if (req_in_frame) state_in = ST_DRW_CNT;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            hist_we   = 1'b1;
            hist_addr = sweep_ff;
            for (int i = 0; i < hrc_pkg::SLOTS; i++) totals_in[i] = '0;
            if (32'(sweep_ff) == MAX_ITER - 1) state_in = ST_IDLE;
            else sweep_in = sweep_ff + 1'b1;
         end
         ST_LOAD_WR: begin
            hist_we    = 1'b1;
            hist_addr  = HIST_AW'(word_ff.iteration_count);
            hist_wdata = (hist_q_ff == hrc_pkg::SUM_SAT) ? hist_q_ff : hist_q_ff + 1'b1;
            state_in   = ST_IDLE;
         end
         ST_TOT_RD: begin
            hist_addr = sweep_ff;
            state_in  = ST_TOT_ACC;
         end
         ST_TOT_ACC: begin
            rng_in = rng_next;
            totals_in[rng_next] = add_tot[SUM_W] ? hrc_pkg::SUM_SAT : add_tot[SUM_W-1:0];
            if (32'(sweep_ff) == MAX_ITER - 1) state_in = ST_IDLE;
            else begin
               sweep_in = sweep_ff + 1'b1;
               state_in = ST_TOT_RD;
            end
         end
         ST_DRW_CNT: begin
            cnt_in  = frm_q_ff;
            sum_in  = '0;
            chan_in = '0;
            rng_in  = draw_rng;
            if (17'(frm_q_ff) >= 17'(MAX_ITER)) begin
               // never escaped: black
               rgb_in   = '0;
               state_in = ST_OUT;
            end else if (draw_start > 16'(frm_q_ff)) begin
               state_in = ST_BLEND_GO;
            end else begin
               walk_in  = CNT_W'(draw_start);
               state_in = ST_DRW_RD;
            end
         end
         ST_DRW_RD: begin
            state_in = ST_DRW_ACC;
         end
         ST_DRW_ACC: begin
            sum_in = add_sum[SUM_W] ? hrc_pkg::SUM_SAT : add_sum[SUM_W-1:0];
            if (walk_ff == cnt_ff) state_in = ST_BLEND_GO;
            else begin
               walk_in  = walk_ff + 1'b1;
               state_in = ST_DRW_RD;
            end
         end
         ST_BLEND_GO: begin
            blend_start = 1'b1;
            state_in    = ST_BLEND_WAIT;
         end
         ST_BLEND_WAIT: begin
            if (blend_done) begin
               rgb_in[8*(2-chan_ff) +: 8] = blend_value;
               if (chan_ff == 2'd2) state_in = ST_OUT;
               else begin
                  chan_in  = chan_ff + 2'd1;
                  state_in = ST_BLEND_GO;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.pixel_position  = word_ff.pixel_index;
               rsp_word_in.red             = rgb_ff[23:16];
               rsp_word_in.green           = rgb_ff[15:8];
               rsp_word_in.blue            = rgb_ff[7:0];
               state_in                    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < hrc_pkg::SLOTS; i++) totals_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         totals_ff    <= totals_in;
      end
      word_ff     <= word_in;
      cnt_ff      <= cnt_in;
      rng_ff      <= rng_in;
      walk_ff     <= walk_in;
      sum_ff      <= sum_in;
      chan_ff     <= chan_in;
      rgb_ff      <= rgb_in;
      rsp_word_ff <= rsp_word_in;
   end

   // configuration registers; range_top has no effect on any color
   always_ff @(posedge clock) begin
      if (reset) begin
         range_count_ff  <= 3'd1;
         range_starts_ff <= '0;
         for (int i = 0; i < 5; i++) color_ff[i] <= '0;
      end else if (csr_write) begin
         case (csr_index)
            hrc_pkg::CSR_RANGE_COUNT:  range_count_ff  <= csr_data[2:0];
            hrc_pkg::CSR_RANGE_STARTS: range_starts_ff <= csr_data;
            hrc_pkg::CSR_RANGE_TOP:    ;
            hrc_pkg::CSR_COLOR_ZERO:   color_ff[0] <= csr_data[23:0];
            hrc_pkg::CSR_COLOR_ONE:    color_ff[1] <= csr_data[23:0];
            hrc_pkg::CSR_COLOR_TWO:    color_ff[2] <= csr_data[23:0];
            hrc_pkg::CSR_COLOR_THREE:  color_ff[3] <= csr_data[23:0];
            default:                   color_ff[4] <= csr_data[23:0];
         endcase
      end
   end

   hrc_blend u_blend (
      .clock (clock),
      .reset (reset),
      .start (blend_start),
      .job   (blend_job),
      .done  (blend_done),
      .value (blend_value)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[src/hrc_checker.sv]
// hrc_checker: port-level checks for histogram_range_colorizer, attached by bind.
// Depends on hrc_pkg.
module hrc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input hrc_pkg::rsp_word_type rsp_word
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // reset starts the clearing pass with no result pending
   a_reset_busy: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("block not busy after reset");

   // a new result only comes out of a draw that kept the input stalled
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while idle");

endmodule

bind histogram_range_colorizer hrc_checker u_hrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
